@@ design/bkh_pkg.sv @@
package bkh_pkg;

    localparam logic [31:0] GOLDEN_RATIO = 32'h9e3779b9;
    localparam logic [31:0] SEED_RESET   = 32'ha205b064;
    localparam logic [3:0]  LAST_POS     = 4'd11;
    localparam logic [3:0]  MIX_LAST     = 4'd8;
    localparam int          QUEUE_DEPTH  = 2;

    typedef enum logic [1:0] {
        CMD_BLOCK,
        CMD_FINAL,
        CMD_BLOCK_FINAL
    } cmd_kind_t;

    // one request from the front end to the mixer
    typedef struct packed {
        logic        first;
        cmd_kind_t   kind;
        logic [31:0] seed;
        logic [31:0] add_a;
        logic [31:0] add_b;
        logic [31:0] add_c;
        logic [31:0] len;
    } cmd_t;

    function automatic logic [4:0] mix_shift(input logic [3:0] step);
        logic [4:0] sh;
        case (step)
            4'd0:    sh = 5'd13;
            4'd1:    sh = 5'd8;
            4'd2:    sh = 5'd13;
            4'd3:    sh = 5'd12;
            4'd4:    sh = 5'd16;
            4'd5:    sh = 5'd5;
            4'd6:    sh = 5'd3;
            4'd7:    sh = 5'd10;
            4'd8:    sh = 5'd15;
            default: sh = 5'd0;
        endcase
        return sh;
    endfunction

endpackage

@@ design/bkh_front.sv @@
module bkh_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         key_byte,
    input  logic               has_byte,
    input  logic               last,
    input  logic [31:0]        seed,
    input  logic               push_ready,
    output logic               push_valid,
    output bkh_pkg::cmd_t      push_cmd
);

    logic [3:0]  pos_reg, pos_next;
    logic [31:0] wa_reg, wa_next;
    logic [31:0] wb_reg, wb_next;
    logic [7:0]  held0_reg, held0_next;
    logic [7:0]  held1_reg, held1_next;
    logic [7:0]  held2_reg, held2_next;
    logic [31:0] count_reg, count_next;
    logic [31:0] key_seed_reg, key_seed_next;
    logic        key_open_reg;
    logic        first_reg;
    logic        accept;
    logic        active;
    logic        blk_done;

    assign s_tready = push_ready;
    assign accept   = s_tvalid && s_tready;
    assign active   = has_byte || last;

    always_comb begin
        wa_next       = wa_reg;
        wb_next       = wb_reg;
        held0_next    = held0_reg;
        held1_next    = held1_reg;
        held2_next    = held2_reg;
        pos_next      = pos_reg;
        count_next    = count_reg;
        blk_done      = 1'b0;
        // latch the seed as the key opens
        key_seed_next = key_open_reg ? key_seed_reg : seed;
        if (has_byte) begin
            case (pos_reg) inside
                [4'd0:4'd3]: wa_next[{pos_reg[1:0], 3'b000} +: 8] = key_byte;
                [4'd4:4'd7]: wb_next[{pos_reg[1:0], 3'b000} +: 8] = key_byte;
                4'd8:        held0_next = key_byte;
                4'd9:        held1_next = key_byte;
                4'd10:       held2_next = key_byte;
                default:     blk_done = 1'b1;
            endcase
            pos_next   = blk_done ? 4'd0 : 4'(pos_reg + 4'd1);
            count_next = count_reg + 32'd1;
        end
    end

    always_comb begin
        push_valid       = accept && (blk_done || last);
        push_cmd.first   = first_reg;
        push_cmd.seed    = key_seed_next;
        push_cmd.add_a   = wa_next;
        push_cmd.add_b   = wb_next;
        push_cmd.len     = count_next;
        if (blk_done) begin
            push_cmd.kind  = last ? bkh_pkg::CMD_BLOCK_FINAL : bkh_pkg::CMD_BLOCK;
            push_cmd.add_c = {key_byte, held2_reg, held1_reg, held0_reg};
        end else begin
            // tail bytes sit above the length byte
            push_cmd.kind  = bkh_pkg::CMD_FINAL;
            push_cmd.add_c = {held2_next, held1_next, held0_next, 8'h00};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= 4'd0;
            wa_reg       <= '0;
            wb_reg       <= '0;
            held0_reg    <= '0;
            held1_reg    <= '0;
            held2_reg    <= '0;
            count_reg    <= '0;
            key_seed_reg <= bkh_pkg::SEED_RESET;
            key_open_reg <= 1'b0;
            first_reg    <= 1'b1;
        end else if (accept && active) begin
            key_seed_reg <= key_seed_next;
            if (blk_done || last) begin
                wa_reg    <= '0;
                wb_reg    <= '0;
                held0_reg <= '0;
                held1_reg <= '0;
                held2_reg <= '0;
            end else begin
                wa_reg    <= wa_next;
                wb_reg    <= wb_next;
                held0_reg <= held0_next;
                held1_reg <= held1_next;
                held2_reg <= held2_next;
            end
            if (last) begin
                pos_reg      <= 4'd0;
                count_reg    <= '0;
                key_open_reg <= 1'b0;
                first_reg    <= 1'b1;
            end else begin
                pos_reg      <= pos_next;
                count_reg    <= count_next;
                key_open_reg <= 1'b1;
                if (blk_done) begin
                    first_reg <= 1'b0;
                end
            end
        end
    end

endmodule

@@ design/bkh_queue.sv @@
module bkh_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  bkh_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop,
    output bkh_pkg::cmd_t pop_cmd
);

    localparam int PTR_W = $clog2(bkh_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(bkh_pkg::QUEUE_DEPTH + 1);

    bkh_pkg::cmd_t    slot_reg [bkh_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (fill_reg != CNT_W'(bkh_pkg::QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(bkh_pkg::QUEUE_DEPTH - 1))
                              ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(bkh_pkg::QUEUE_DEPTH - 1))
                              ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
            end
            if (do_push && !do_pop) begin
                fill_reg <= CNT_W'(fill_reg + 1'b1);
            end else if (do_pop && !do_push) begin
                fill_reg <= CNT_W'(fill_reg - 1'b1);
            end
        end
    end

endmodule

@@ design/bkh_back.sv @@
module bkh_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cmd_valid,
    output logic          cmd_pop,
    input  bkh_pkg::cmd_t cmd,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [31:0]   m_tdata
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MIX,
        ST_LEN
    } state_t;

    state_t             state_reg, state_next;
    logic [31:0]        a_reg, a_next;
    logic [31:0]        b_reg, b_next;
    logic [31:0]        c_reg, c_next;
    logic [3:0]         step_reg, step_next;
    bkh_pkg::cmd_kind_t kind_reg, kind_next;
    logic [31:0]        len_reg, len_next;
    logic               out_valid_reg, out_valid_next;
    logic [31:0]        out_data_reg, out_data_next;

    logic [31:0] base_a, base_b, base_c;
    logic [31:0] op_x, op_y, op_z;
    logic [31:0] mixed;
    logic [4:0]  sh;
    logic        shift_left;
    logic        out_free;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign out_free = !out_valid_reg || m_tready;
    assign cmd_pop  = (state_reg == ST_IDLE) && cmd_valid;

    // one mix line per cycle unless output stalls; target rotates a, b, c
    always_comb begin
        sh         = bkh_pkg::mix_shift(step_reg);
        shift_left = 1'b0;
        case (step_reg) inside
            4'd0, 4'd3, 4'd6: begin
                op_x = a_reg; op_y = b_reg; op_z = c_reg;
            end
            4'd1, 4'd4, 4'd7: begin
                op_x = b_reg; op_y = c_reg; op_z = a_reg;
                shift_left = 1'b1;
            end
            default: begin
                op_x = c_reg; op_y = a_reg; op_z = b_reg;
            end
        endcase
        mixed = (op_x - op_y - op_z) ^ (shift_left ? (op_z << sh) : (op_z >> sh));
    end

    always_comb begin
        base_a = cmd.first ? bkh_pkg::GOLDEN_RATIO : a_reg;
        base_b = cmd.first ? bkh_pkg::GOLDEN_RATIO : b_reg;
        base_c = cmd.first ? cmd.seed : c_reg;
    end

    always_comb begin
        state_next     = state_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        step_next      = step_reg;
        kind_next      = kind_reg;
        len_next       = len_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    a_next     = base_a + cmd.add_a;
                    b_next     = base_b + cmd.add_b;
                    c_next     = base_c + cmd.add_c
                                 + ((cmd.kind == bkh_pkg::CMD_FINAL) ? cmd.len : 32'd0);
                    kind_next  = cmd.kind;
                    len_next   = cmd.len;
                    step_next  = 4'd0;
                    state_next = ST_MIX;
                end
            end
            ST_MIX: begin
                if (step_reg != bkh_pkg::MIX_LAST || kind_reg != bkh_pkg::CMD_FINAL
                        || out_free) begin
                    case (step_reg) inside
                        4'd0, 4'd3, 4'd6: a_next = mixed;
                        4'd1, 4'd4, 4'd7: b_next = mixed;
                        default:          c_next = mixed;
                    endcase
                    step_next = 4'(step_reg + 4'd1);
                    if (step_reg == bkh_pkg::MIX_LAST) begin
                        case (kind_reg)
                            bkh_pkg::CMD_FINAL: begin
                                out_valid_next = 1'b1;
                                out_data_next  = mixed;
                                state_next     = ST_IDLE;
                            end
                            bkh_pkg::CMD_BLOCK_FINAL: begin
                                state_next = ST_LEN;
                            end
                            default: begin
                                state_next = ST_IDLE;
                            end
                        endcase
                    end
                end
            end
            ST_LEN: begin
                // block closed the key: add the length, then the closing mix
                c_next     = c_reg + len_reg;
                kind_next  = bkh_pkg::CMD_FINAL;
                step_next  = 4'd0;
                state_next = ST_MIX;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= 4'd0;
            kind_reg      <= bkh_pkg::CMD_BLOCK;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
        end
        a_reg        <= a_next;
        b_reg        <= b_next;
        c_reg        <= c_next;
        len_reg      <= len_next;
        out_data_reg <= out_data_next;
    end

endmodule

@@ design/byte_key_hash_lookup2_core.sv @@
// Streaming lookup2 hash of a byte key.
// Input channel (s_*): one request per cycle while s_tready is high; s_tdata carries the key byte,
// s_tuser says whether the byte is part of the key, s_tlast ends the key.
// A request with neither flag set is dropped. A key may be empty.
// Output channel (m_*): one 32-bit hash per key, on m_tdata.
// cfg_we/cfg_wdata write the seed; a key uses the seed present at its first
// request.
// The front end packs bytes into 12-byte blocks and hands block and final
// requests through a two-entry queue to a mixer that loads a request and
// then does one mix line per cycle, holding at the last line of a final
// mix while the output register is full and m_tready is low. When the last
// byte also completes a block, the mixer adds the length after the block
// mix and then mixes again. Long keys stream at one byte per cycle while the
// queue has room; a run of short keys is paced by the mixer.
// Reset clears the key state, empties the queue, drops m_tvalid and loads
// the seed with 0xa205b064.
// While m_tready is low the result holds in the output register; the mixer
// then waits at its last step, the queue fills and s_tready falls.
module byte_key_hash_lookup2_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] key_byte
    input  logic        s_tuser,   // [0] has_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] hash_value
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);

    logic [31:0]   seed_reg;
    logic          push_valid;
    logic          push_ready;
    bkh_pkg::cmd_t push_cmd;
    logic          pop_valid;
    logic          pop;
    bkh_pkg::cmd_t pop_cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= bkh_pkg::SEED_RESET;
        end else if (cfg_we) begin
            seed_reg <= cfg_wdata;
        end
    end

    bkh_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .key_byte   (s_tdata),
        .has_byte   (s_tuser),
        .last       (s_tlast),
        .seed       (seed_reg),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_cmd   (push_cmd)
    );

    bkh_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_cmd    (pop_cmd)
    );

    bkh_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (pop_valid),
        .cmd_pop   (pop),
        .cmd       (pop_cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

@@ design/bkh_checker.sv @@
module bkh_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // keys closed at the input and not yet delivered
    logic [2:0] open_keys_reg;
    logic       key_in;
    logic       key_out;

    assign key_in  = s_tvalid && s_tready && s_tlast;
    assign key_out = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_keys_reg <= 3'd0;
        end else if (key_in && !key_out) begin
            open_keys_reg <= 3'(open_keys_reg + 3'd1);
        end else if (key_out && !key_in) begin
            open_keys_reg <= 3'(open_keys_reg - 3'd1);
        end
    end

    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_no_orphan: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> open_keys_reg != 3'd0)
        else $error("result without a closed key");

    a_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        open_keys_reg <= 3'd4)
        else $error("too many keys in flight");

endmodule

bind byte_key_hash_lookup2_core bkh_checker u_bkh_checker (.*);
